### rtl/knt_pkg.sv
// Shared types and constants for the k-nomial tree neighbor lookup.
package knt_pkg;

   localparam int MAX_NODES = 1024;
   localparam int MAX_RADIX = 16;
   localparam int NODE_W    = 10;
   localparam int SIZE_W    = 11;
   localparam int RADIX_W   = 5;
   localparam int ORD_W     = 6;
   localparam int DIV_W     = 11;
   localparam int DCNT_W    = $clog2(DIV_W + 1);

   // Configuration register indexes
   localparam logic CSR_NODE_CNT = 1'b0;
   localparam logic CSR_RADIX    = 1'b1;

   // Which quotient the shared divider computes
   typedef enum logic [1:0] {
      DIV_DIST   = 2'd0,
      DIV_GROUP  = 2'd1,
      DIV_QCHILD = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'd0,
      ST_PAR_CHK   = 4'd1,
      ST_PAR_DIST  = 4'd2,
      ST_PAR_GRP0  = 4'd3,
      ST_PAR_GRP   = 4'd4,
      ST_CH_CHK    = 4'd5,
      ST_CH_DIST   = 4'd6,
      ST_CH_Q0     = 4'd7,
      ST_CH_Q      = 4'd8,
      ST_EMIT      = 4'd9,
      ST_EMIT_LEAF = 4'd10,
      ST_EMIT_BAD  = 4'd11
   } state_type;

   typedef struct packed {
      logic        ld_node;
      logic        div_start;
      div_sel_type div_sel;
      logic        ld_dist;
      logic        par_step;
      logic        ch_first;
      logic        emit_child;
      logic        emit_leaf;
      logic        emit_bad;
   } cmd_type;

   typedef struct packed {
      logic node_bad;
      logic at_node;
      logic w_le1;
      logic div_done;
      logic out_free;
      logic next_in_level;
      logic last_child;
   } status_type;

endpackage

### rtl/knomial_tree_node_neighbors.sv
// Top level of the k-nomial tree neighbor lookup.
//
//  channel | ports                              | contents (lowest bit first)
//  --------+------------------------------------+-------------------------------------------
//  request | req_tvalid/tready/tdata[15:0]      | node[9:0]
//  result  | rsp_tvalid/tready/tdata/tuser/tlast| tdata: parent, child, child_ordinal;
//          |                                    | tuser: is_root, has_child, bad_node
//  config  | csr_valid/ready/index/data[10:0]   | index 0 node count, index 1 radix
//
// One node at a time. Each interval level costs two divisions on the shared
// divider, for the parent walk and for each child level; then each child is
// emitted as its own result beat. Reset is synchronous, active high; the node
// count resets to 1, radix to 2. A stalled result holds the block in its emit
// state; the last result may wait in the output register while the next node
// is taken.
module knomial_tree_node_neighbors
   import knt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // node[9:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // parent[9:0], child[19:10], child_ordinal[25:20]
   output logic [2:0]        rsp_tuser,   // is_root[0], has_child[1], bad_node[2]
   output logic              rsp_tlast,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   knt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   knt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .node       (req_tdata[NODE_W-1:0]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a node beat keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a node is in progress");

   // bad-node and childless results end the node
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tlast && !rsp_tuser[1])
      else $error("bad-node result not final or carries a child");

   a_nochild_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tlast && rsp_tdata[25:10] == 16'd0)
      else $error("childless result not final or has child fields");

   // the root reports parent zero
   a_root_parent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[9:0] == 10'd0)
      else $error("root result with nonzero parent");

endmodule

### rtl/knt_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module knt_div
   import knt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             done
);

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsr_ff;
   logic [DIV_W:0]    shifted;
   logic [DIV_W+1:0]  diff;

   // trial subtraction of the next partial remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      if (!diff[DIV_W+1]) begin
         rem_in = diff[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // one-cycle pulse as the last quotient bit lands
         done_ff <= busy_ff && !start && (cnt_ff == DCNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DCNT_W'(1))
               busy_ff <= 1'b0;
         end
      end
   end

   // operand and partial result registers
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

### rtl/knt_dp.sv
// Datapath: config registers, interval registers, divider and result register.
module knt_dp
   import knt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_data,
   input  logic [NODE_W-1:0] node,
   input  cmd_type           cmd,
   output status_type        sts,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast
);

   logic [SIZE_W-1:0]  node_cnt_ff;
   logic [RADIX_W-1:0] radix_ff;
   logic [NODE_W-1:0]  node_ff;
   logic [SIZE_W-1:0]  n_ff;
   logic [RADIX_W-1:0] k_ff;
   logic [SIZE_W-1:0]  left_ff, right_ff, dist_ff, c_ff;
   logic [NODE_W-1:0]  parent_ff;
   logic               root_ff;
   logic [ORD_W-1:0]   ord_ff;

   logic               out_valid_ff;
   logic [NODE_W-1:0]  o_parent_ff, o_child_ff;
   logic               o_root_ff, o_has_ff, o_last_ff, o_bad_ff;
   logic [ORD_W-1:0]   o_ord_ff;

   logic [SIZE_W-1:0]  n_in;
   logic [RADIX_W-1:0] k_in;
   logic [SIZE_W-1:0]  w, c_next;
   logic [DIV_W-1:0]   dvd, dsr, quo;
   logic               div_done;
   logic [2*DIV_W-1:0] prod_full;
   logic [SIZE_W:0]    prod, nr;
   logic               next_in_level, last_child, out_free, emit_any;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_cnt_ff <= SIZE_W'(1);
         radix_ff    <= RADIX_W'(2);
      end else if (csr_we) begin
         case (csr_index)
            CSR_NODE_CNT: node_cnt_ff <= csr_data;
            CSR_RADIX:    radix_ff    <= csr_data[RADIX_W-1:0];
            default:      ;
         endcase
      end
   end

   // clamp size and radix into the supported range
   always_comb begin
      n_in = (node_cnt_ff > SIZE_W'(MAX_NODES)) ? SIZE_W'(MAX_NODES) : node_cnt_ff;
      if (radix_ff < RADIX_W'(2))
         k_in = RADIX_W'(2);
      else if (radix_ff > RADIX_W'(MAX_RADIX))
         k_in = RADIX_W'(MAX_RADIX);
      else
         k_in = radix_ff;
   end

   // divider operand selection
   assign w = right_ff - left_ff;
   always_comb begin
      dsr = dist_ff;
      case (cmd.div_sel)
         DIV_DIST: begin
            dvd = w + {{(SIZE_W-RADIX_W){1'b0}}, k_ff} - SIZE_W'(1);
            dsr = {{(SIZE_W-RADIX_W){1'b0}}, k_ff};
         end
         DIV_GROUP:  dvd = {1'b0, node_ff} - left_ff;
         DIV_QCHILD: dvd = w - SIZE_W'(1);
         default:    dvd = '0;
      endcase
   end

   knt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dsr),
      .quotient (quo),
      .done     (div_done)
   );

   // quotient times group width, bounded below 2^12
   assign prod_full     = quo * dist_ff;
   assign prod          = prod_full[SIZE_W:0];
   assign nr            = {1'b0, left_ff} + prod + {1'b0, dist_ff};
   assign c_next        = c_ff - dist_ff;
   assign next_in_level = c_next > left_ff;
   assign last_child    = (ord_ff == {ORD_W{1'b1}}) ||
                          (!next_in_level && dist_ff <= SIZE_W'(1));

   // interval walk registers
   always_ff @(posedge clock) begin
      if (cmd.ld_node) begin
         node_ff   <= node;
         n_ff      <= n_in;
         k_ff      <= k_in;
         left_ff   <= '0;
         right_ff  <= n_in;
         parent_ff <= '0;
         root_ff   <= 1'b1;
         ord_ff    <= '0;
      end
      if (cmd.ld_dist)
         dist_ff <= quo;
      if (cmd.par_step) begin
         parent_ff <= left_ff[NODE_W-1:0];
         root_ff   <= 1'b0;
         left_ff   <= left_ff + prod[SIZE_W-1:0];
         if (nr < {1'b0, right_ff})
            right_ff <= nr[SIZE_W-1:0];
      end
      if (cmd.ch_first)
         c_ff <= left_ff + prod[SIZE_W-1:0];
      if (cmd.emit_child && !last_child) begin
         ord_ff <= ord_ff + 1'b1;
         if (next_in_level)
            c_ff <= c_next;
         else
            right_ff <= left_ff + dist_ff;
      end
   end

   // result register, loaded while empty or being drained
   assign out_free = !out_valid_ff || rsp_tready;
   assign emit_any = cmd.emit_child || cmd.emit_leaf || cmd.emit_bad;

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (emit_any)
         out_valid_ff <= 1'b1;
      else if (rsp_tready)
         out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (emit_any) begin
         o_parent_ff <= cmd.emit_bad ? '0 : parent_ff;
         o_root_ff   <= cmd.emit_bad ? 1'b0 : root_ff;
         o_child_ff  <= cmd.emit_child ? c_ff[NODE_W-1:0] : '0;
         o_has_ff    <= cmd.emit_child;
         o_ord_ff    <= cmd.emit_child ? ord_ff : '0;
         o_last_ff   <= cmd.emit_child ? last_child : 1'b1;
         o_bad_ff    <= cmd.emit_bad;
      end
   end

   // status back to the controller
   always_comb begin
      sts.node_bad      = {1'b0, node_ff} >= n_ff;
      sts.at_node       = {1'b0, node_ff} == left_ff;
      sts.w_le1         = w <= SIZE_W'(1);
      sts.div_done      = div_done;
      sts.out_free      = out_free;
      sts.next_in_level = next_in_level;
      sts.last_child    = last_child;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, o_ord_ff, o_child_ff, o_parent_ff};
   assign rsp_tuser  = {o_bad_ff, o_has_ff, o_root_ff};
   assign rsp_tlast  = o_last_ff;

endmodule

### rtl/knt_ctrl.sv
// Controller: sequences the parent search, the child levels and the result beats.
module knt_ctrl
   import knt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.div_sel = DIV_DIST;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.ld_node = 1'b1;
               state_in    = ST_PAR_CHK;
            end
         end
         // narrow the interval until it starts at the node
         ST_PAR_CHK: begin
            if (sts.node_bad)
               state_in = ST_EMIT_BAD;
            else if (sts.at_node)
               state_in = ST_CH_CHK;
            else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_DIST;
               state_in      = ST_PAR_DIST;
            end
         end
         ST_PAR_DIST: begin
            if (sts.div_done) begin
               cmd.ld_dist = 1'b1;
               state_in    = ST_PAR_GRP0;
            end
         end
         ST_PAR_GRP0: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_GROUP;
            state_in      = ST_PAR_GRP;
         end
         ST_PAR_GRP: begin
            if (sts.div_done) begin
               cmd.par_step = 1'b1;
               state_in     = ST_PAR_CHK;
            end
         end
         // split the node's own interval, one level at a time
         ST_CH_CHK: begin
            if (sts.w_le1)
               state_in = ST_EMIT_LEAF;
            else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_DIST;
               state_in      = ST_CH_DIST;
            end
         end
         ST_CH_DIST: begin
            if (sts.div_done) begin
               cmd.ld_dist = 1'b1;
               state_in    = ST_CH_Q0;
            end
         end
         ST_CH_Q0: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_QCHILD;
            state_in      = ST_CH_Q;
         end
         ST_CH_Q: begin
            if (sts.div_done) begin
               cmd.ch_first = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_child = 1'b1;
               if (sts.last_child)
                  state_in = ST_IDLE;
               else if (!sts.next_in_level)
                  state_in = ST_CH_CHK;
            end
         end
         ST_EMIT_LEAF: begin
            if (sts.out_free) begin
               cmd.emit_leaf = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EMIT_BAD: begin
            if (sts.out_free) begin
               cmd.emit_bad = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### sim/tb_knomial_tree_node_neighbors.sv
// Self-checking testbench for the k-nomial tree neighbor lookup block.
module tb_knomial_tree_node_neighbors
   import knt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHILD_CAP   = 64;
   localparam int SETTLE_CYC  = 8;
   localparam int RAND_PHASES = 10;
   localparam int PHASE_ITEMS = 25;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One expected result beat
   typedef struct packed {
      logic [NODE_W-1:0] parent;
      logic              is_root;
      logic [NODE_W-1:0] child;
      logic              has_child;
      logic [ORD_W-1:0]  ordinal;
      logic              last;
      logic              bad_node;
   } nbr_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [15:0]       req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic [2:0]        rsp_tuser;
   logic              rsp_tlast;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_index = CSR_NODE_CNT;
   logic [SIZE_W-1:0] csr_data = '0;

   // Shadow copy of the configuration registers
   logic [SIZE_W-1:0]  cfg_size  = 11'd1;
   logic [RADIX_W-1:0] cfg_radix = 5'd2;

   nbr_result_type nbr_q[$];

   int idle_pct  = 0;
   int stall_pct = 0;
   int n_errors  = 0;
   int n_items   = 0;
   int n_configs = 0;
   int n_beats   = 0;
   int n_child   = 0;
   int n_leaf    = 0;
   int n_bad     = 0;

   knomial_tree_node_neighbors i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Hard limit on run time
   initial begin
      #5000000;
      $display("knomial_tree_node_neighbors test failed");
      $finish;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Parent walk, then children farthest level first, higher index first
   function automatic void predict_neighbors(input logic [NODE_W-1:0] node);
      int unsigned n, k, lo, hi, par, w, span, grp, nr, c;
      logic        root;
      int unsigned kids[$];
      nbr_result_type r;
      n = (cfg_size > MAX_NODES) ? MAX_NODES : cfg_size;
      k = (cfg_radix < 2) ? 2 : ((cfg_radix > MAX_RADIX) ? MAX_RADIX : cfg_radix);
      r = '0;
      r.last = 1'b1;
      if (node >= n) begin
         r.bad_node = 1'b1;
         nbr_q.push_back(r);
         return;
      end
      lo   = 0;
      hi   = n;
      par  = 0;
      root = 1'b1;
      while (node != lo) begin
         w    = hi - lo;
         span = (w + k - 1) / k;
         par  = lo;
         root = 1'b0;
         if (span == 0) break;
         grp = (node - lo) / span;
         nr  = lo + (grp + 1) * span;
         if (nr < hi) hi = nr;
         lo += grp * span;
      end
      while (kids.size() < CHILD_CAP) begin
         w = hi - lo;
         if (w <= 1) break;
         span = (w + k - 1) / k;
         c    = lo + span * ((w - 1) / span);
         if (c == lo) break;
         while (c > lo && kids.size() < CHILD_CAP) begin
            kids.push_back(c);
            c -= span;
         end
         hi = lo + span;
      end
      r.parent  = par[NODE_W-1:0];
      r.is_root = root;
      if (kids.size() == 0) begin
         nbr_q.push_back(r);
      end else begin
         foreach (kids[i]) begin
            r.child     = kids[i][NODE_W-1:0];
            r.has_child = 1'b1;
            r.ordinal   = i[ORD_W-1:0];
            r.last      = (i == kids.size() - 1);
            nbr_q.push_back(r);
         end
      end
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         n_errors++;
      end
   endtask

   // Result checker
   always @(posedge clock) begin : rsp_check
      nbr_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.parent    = rsp_tdata[NODE_W-1:0];
         got.child     = rsp_tdata[2*NODE_W-1:NODE_W];
         got.ordinal   = rsp_tdata[2*NODE_W+ORD_W-1:2*NODE_W];
         got.is_root   = rsp_tuser[0];
         got.has_child = rsp_tuser[1];
         got.bad_node  = rsp_tuser[2];
         got.last      = rsp_tlast;
         n_beats++;
         if (nbr_q.size() == 0) begin
            $error("unexpected result beat: parent %0d child %0d", got.parent, got.child);
            n_errors++;
         end else begin
            want = nbr_q.pop_front();
            check_field("parent", want.parent, got.parent);
            check_field("is_root", want.is_root, got.is_root);
            check_field("child", want.child, got.child);
            check_field("has_child", want.has_child, got.has_child);
            check_field("child_ordinal", want.ordinal, got.ordinal);
            check_field("last", want.last, got.last);
            check_field("bad_node", want.bad_node, got.bad_node);
            if (want.bad_node) n_bad++;
            else if (want.has_child) n_child++;
            else n_leaf++;
         end
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      idle_pct  = (mode == IDLE_SENDER || mode == IDLE_BOTH) ?
                  ((mode == IDLE_BOTH) ? 9 : 86) : 0;
      stall_pct = (mode == IDLE_RECEIVER || mode == IDLE_BOTH) ?
                  ((mode == IDLE_BOTH) ? 9 : 86) : 0;
   endtask

   // Hold off the sender until every expected beat has arrived
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (nbr_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Send one node query; valid stays high into a back-to-back beat
   task automatic send_node(input logic [NODE_W-1:0] node);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, node};
      predict_neighbors(node);
      n_items++;
      do @(posedge clock); while (!req_tready);
   endtask

   // Write both registers while the block is idle
   task automatic set_config(input logic [SIZE_W-1:0] size, input logic [RADIX_W-1:0] rdx);
      drain_block();
      csr_valid <= 1'b1;
      csr_index <= CSR_NODE_CNT;
      csr_data  <= size;
      do @(posedge clock); while (!csr_ready);
      cfg_size  = size;
      csr_index <= CSR_RADIX;
      csr_data  <= {(SIZE_W-RADIX_W)'($urandom), rdx};
      do @(posedge clock); while (!csr_ready);
      cfg_radix = rdx;
      csr_valid <= 1'b0;
      n_configs++;
   endtask

   // Queries against the reset configuration: one-node tree
   task automatic test_reset_defaults();
      set_idling(IDLE_NONE);
      send_node(10'd0);
      send_node(10'd1);
      send_node(10'd1023);
   endtask

   // Largest trees at the smallest and largest radix, then a 1000-node tree at radix 3
   task automatic test_full_trees();
      set_config(11'd1024, 5'd2);
      send_node(10'd0);
      send_node(10'd1);
      send_node(10'd512);
      send_node(10'd341);
      send_node(10'd1023);
      set_config(11'd1024, 5'd16);
      send_node(10'd0);
      send_node(10'd64);
      send_node(10'd5);
      send_node(10'd1023);
      set_config(11'd1000, 5'd3);
      send_node(10'd0);
      send_node(10'd999);
   endtask

   // Empty tree, oversize tree and radix clamping on both sides
   task automatic test_saturation();
      set_config(11'd0, 5'd0);
      send_node(10'd0);
      set_config(11'd2047, 5'd31);
      send_node(10'd0);
      send_node(10'd1023);
      set_config(11'd1025, 5'd1);
      send_node(10'd0);
      send_node(10'd777);
      send_node(10'd1023);
      set_config(11'd2, 5'd17);
      send_node(10'd0);
      send_node(10'd1);
      send_node(10'd2);
   endtask

   // Random trees and nodes, cycling through the idling patterns
   task automatic test_random();
      int unsigned n_eff;
      logic [SIZE_W-1:0]  size;
      logic [RADIX_W-1:0] rdx;
      logic [NODE_W-1:0]  node;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(4))
            0: size = SIZE_W'($urandom_range(16, 1));
            1, 2: size = SIZE_W'($urandom_range(1024, 1));
            3: size = SIZE_W'($urandom_range(1024, 900));
            default: size = SIZE_W'($urandom_range(2047, 0));
         endcase
         if ($urandom_range(4) == 0) rdx = RADIX_W'($urandom_range(31, 0));
         else rdx = RADIX_W'($urandom_range(MAX_RADIX, 2));
         set_config(size, rdx);
         set_idling(idle_mode_type'(ph % 4));
         n_eff = (size > MAX_NODES) ? MAX_NODES : size;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (n_eff > 0 && $urandom_range(99) < 85)
               node = NODE_W'($urandom_range(n_eff - 1, 0));
            else
               node = NODE_W'($urandom_range(1023, 0));
            send_node(node);
         end
      end
   endtask

   initial begin
      int guard;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_full_trees();
      test_saturation();
      test_random();
      req_tvalid <= 1'b0;
      guard = 0;
      while (nbr_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4 * SETTLE_CYC) @(posedge clock);
      if (nbr_q.size() != 0) begin
         $error("%0d expected result beats never arrived", nbr_q.size());
         n_errors++;
      end
      $display("Covered %0d node queries over %0d tree settings, four idling patterns.",
               n_items, n_configs);
      $display("Checked %0d result beats: %0d children, %0d leaves, %0d out-of-tree.",
               n_beats, n_child, n_leaf, n_bad);
      if (n_errors == 0) begin
         $display("knomial_tree_node_neighbors test passed");
      end else begin
         $display("knomial_tree_node_neighbors test failed");
      end
      $finish;
   end

endmodule
